// ===== rtl/scfr_pkg.sv =====
// Package for the serial command frame receiver.
// Holds the transaction structs, kind codes, header characters and sizes.
// No dependencies.
package scfr_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int LEN_W       = 7;
	localparam int POS_W       = 6;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_R      = 8'h52;

	typedef enum logic [2:0] {
		KIND_PAYLOAD      = 3'd0,
		KIND_EMPTY        = 3'd1,
		KIND_CONSOLE_REQ  = 3'd2,
		KIND_RESET_REQ    = 3'd3,
		KIND_CONSOLE_PASS = 3'd4
	} scfr_kind_t;

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_START = 6'b000010,
		PH_M     = 6'b000100,
		PH_ARROW = 6'b001000,
		PH_SIZE  = 6'b010000,
		PH_BODY  = 6'b100000
	} scfr_phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       armed;
		logic       console_mode;
	} scfr_in_t;

	typedef struct packed {
		scfr_kind_t       kind;
		logic [7:0]       command;
		logic [LEN_W-1:0] length;
		logic [POS_W-1:0] position;
		logic [7:0]       data;
		logic             last;
	} scfr_out_t;

	typedef struct packed {
		logic             push;
		scfr_out_t        item;
		logic             start;
		logic [7:0]       command;
		logic [LEN_W-1:0] length;
	} scfr_ctl_t;

endpackage

// ===== rtl/serial_command_frame_receiver_top.sv =====
// Top level of the serial command frame receiver.
// Depends on scfr_pkg, scfr_ram, scfr_parser and scfr_emit.
//
//   channel  valid      stall      payload   direction
//   input    in_valid   in_stall   in_item   byte into the block
//   output   out_valid  out_stall  out_item  result out of the block
//
// A received byte updates the parser registers and,
// in the payload phase, one entry of the 64-entry payload memory.
// A verified frame of N payload bytes is replayed from the memory read port,
// one byte per cycle when the output is not stalled; no byte is taken until the
// replay has been queued.
// Reset clears the parser and the result queue; the payload memory is not cleared.
// Output stalls hold the two-entry result queue, which stalls the input once full.
module serial_command_frame_receiver_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  scfr_pkg::scfr_in_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output scfr_pkg::scfr_out_t out_item
);
	import scfr_pkg::*;

	logic              accept;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	scfr_ctl_t         ctl;

	assign accept = in_valid && !in_stall;

	scfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_item (in_item),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.ctl     (ctl)
	);

	scfr_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	scfr_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rd_data   (rd_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item),
		.in_stall  (in_stall)
	);

endmodule

// ===== rtl/scfr_ram.sv =====
// Payload memory of the frame receiver: one write port, one registered read port.
// Depends on scfr_pkg for the depth and address width.
module scfr_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [scfr_pkg::ADDR_W-1:0] wr_addr,
	input  logic [7:0]                 wr_data,
	input  logic                       rd_en,
	input  logic [scfr_pkg::ADDR_W-1:0] rd_addr,
	output logic [7:0]                 rd_data
);
	import scfr_pkg::*;

	logic [7:0] mem [MAX_PAYLOAD];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/scfr_parser.sv =====
// Frame parser: header recognition, checksum, payload writes and single results.
// Depends on scfr_pkg; drives the payload memory write port and the result unit.
module scfr_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  scfr_pkg::scfr_in_t          in_item,
	output logic                        wr_en,
	output logic [scfr_pkg::ADDR_W-1:0] wr_addr,
	output logic [7:0]                  wr_data,
	output scfr_pkg::scfr_ctl_t         ctl
);
	import scfr_pkg::*;

	scfr_phase_t      phase_q, phase_d;
	logic [7:0]       xor_q, xor_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [7:0]       c;

	assign c       = in_item.rx_byte;
	assign wr_addr = cnt_q[ADDR_W-1:0];
	assign wr_data = c;

	always_comb begin
		phase_d = phase_q;
		xor_d   = xor_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		cmd_d   = cmd_q;
		wr_en   = 1'b0;
		ctl     = '0;
		if (accept) begin
			if (in_item.console_mode) begin
				ctl.push      = 1'b1;
				ctl.item.kind = KIND_CONSOLE_PASS;
				ctl.item.data = c;
				ctl.item.last = 1'b1;
			end else begin
				case (phase_q)
					PH_START: begin
						phase_d = (c == CH_M) ? PH_M : PH_IDLE;
					end
					PH_M: begin
						phase_d = (c == CH_LT) ? PH_ARROW : PH_IDLE;
					end
					PH_ARROW: begin
						if (c > 8'(MAX_PAYLOAD)) begin
							phase_d = PH_IDLE;
						end else begin
							len_d   = c[LEN_W-1:0];
							cnt_d   = '0;
							xor_d   = c;
							phase_d = PH_SIZE;
						end
					end
					PH_SIZE: begin
						cmd_d   = c;
						xor_d   = xor_q ^ c;
						phase_d = PH_BODY;
					end
					PH_BODY: begin
						if (cnt_q < len_q) begin
							xor_d = xor_q ^ c;
							wr_en = 1'b1;
							cnt_d = cnt_q + 1'b1;
						end else begin
							if (xor_q == c) begin
								if (len_q == '0) begin
									ctl.push         = 1'b1;
									ctl.item.kind    = KIND_EMPTY;
									ctl.item.command = cmd_q;
									ctl.item.last    = 1'b1;
								end else begin
									ctl.start   = 1'b1;
									ctl.command = cmd_q;
									ctl.length  = len_q;
								end
							end
							phase_d = PH_IDLE;
						end
					end
					default: begin
						phase_d = (c == CH_DOLLAR) ? PH_START : PH_IDLE;
						if (!in_item.armed && c == CH_HASH) begin
							ctl.push      = 1'b1;
							ctl.item.kind = KIND_CONSOLE_REQ;
							ctl.item.data = c;
							ctl.item.last = 1'b1;
						end else if (!in_item.armed && c == CH_R) begin
							ctl.push      = 1'b1;
							ctl.item.kind = KIND_RESET_REQ;
							ctl.item.data = c;
							ctl.item.last = 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			xor_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			cmd_q   <= '0;
		end else begin
			phase_q <= phase_d;
			xor_q   <= xor_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			cmd_q   <= cmd_d;
		end
	end

endmodule

// ===== rtl/scfr_emit.sv =====
// Result unit: payload replay sequencer, memory read port and two-entry output queue.
// Depends on scfr_pkg; takes control from scfr_parser and read data from scfr_ram.
module scfr_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  scfr_pkg::scfr_ctl_t         ctl,
	input  logic [7:0]                  rd_data,
	output logic                        rd_en,
	output logic [scfr_pkg::ADDR_W-1:0] rd_addr,
	input  logic                        out_stall,
	output logic                        out_valid,
	output scfr_pkg::scfr_out_t         out_item,
	output logic                        in_stall
);
	import scfr_pkg::*;

	logic             rep_active_q;
	logic [LEN_W-1:0] rep_idx_q;
	logic [LEN_W-1:0] rep_len_q;
	logic [7:0]       rep_cmd_q;
	logic             rd_pend_s1;
	logic [POS_W-1:0] pos_s1;
	logic             last_s1;
	logic [1:0]       count_q;
	scfr_out_t        e0_q, e1_q;
	logic             pop, push, issue, idx_last;
	logic [2:0]       occ;
	scfr_out_t        push_item;

	assign pop      = out_valid && !out_stall;
	assign occ      = {1'b0, count_q} + {2'b00, rd_pend_s1} - {2'b00, pop};
	assign issue    = rep_active_q && (occ < 3'd2);
	assign idx_last = (rep_idx_q + 1'b1) == rep_len_q;
	assign rd_en    = issue;
	assign rd_addr  = rep_idx_q[ADDR_W-1:0];

	assign push = ctl.push || rd_pend_s1;

	always_comb begin
		if (rd_pend_s1) begin
			push_item.kind     = KIND_PAYLOAD;
			push_item.command  = rep_cmd_q;
			push_item.length   = rep_len_q;
			push_item.position = pos_s1;
			push_item.data     = rd_data;
			push_item.last     = last_s1;
		end else begin
			push_item = ctl.item;
		end
	end

	assign out_valid = (count_q != 2'd0);
	assign out_item  = e0_q;
	assign in_stall  = rep_active_q || rd_pend_s1 || (count_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_active_q <= 1'b0;
			rd_pend_s1   <= 1'b0;
			count_q      <= '0;
		end else begin
			rd_pend_s1 <= issue;
			if (ctl.start) begin
				rep_active_q <= 1'b1;
			end else if (issue && idx_last) begin
				rep_active_q <= 1'b0;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rep_idx_q <= '0;
			rep_len_q <= ctl.length;
			rep_cmd_q <= ctl.command;
		end else if (issue) begin
			rep_idx_q <= rep_idx_q + 1'b1;
		end
		if (issue) begin
			pos_s1  <= rep_idx_q[POS_W-1:0];
			last_s1 <= idx_last;
		end
		if (push && (count_q == 2'd0 || (count_q == 2'd1 && pop))) begin
			e0_q <= push_item;
		end
		if (push && count_q == 2'd1 && !pop) begin
			e1_q <= push_item;
		end
		if (count_q == 2'd2 && pop) begin
			e0_q <= e1_q;
			if (push) begin
				e1_q <= push_item;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2 || pop))
		else $error("result queue overflow");

	a_single_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.push && rd_pend_s1))
		else $error("parser result collides with replay data");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> (!rep_active_q && !rd_pend_s1))
		else $error("replay started while a replay is running");

endmodule
